// ===== hdl/fifo_cache_hit_cost_counter_macros.svh =====
// Assertion shorthands shared by the RTL. Each expects clk and rst_n in scope.
`ifndef FIFO_CACHE_HIT_COST_COUNTER_MACROS_SVH
`define FIFO_CACHE_HIT_COST_COUNTER_MACROS_SVH

// Condition that holds at every clock edge outside reset.
`define FHC_ASSERT_HOLD(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define FHC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FHC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/fhc_pkg.sv =====
package fhc_pkg;

  localparam int KEY_W      = 64;
  localparam int CAP_W      = 6;
  localparam int COST_W     = 8;
  localparam int TOTAL_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIT_COST  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MISS_COST = 2'd2;

  localparam logic [CAP_W-1:0]  CAPACITY_RST  = 6'd0;
  localparam logic [COST_W-1:0] HIT_COST_RST  = 8'd1;
  localparam logic [COST_W-1:0] MISS_COST_RST = 8'd5;

  typedef struct packed {
    logic              add;
    logic [COST_W-1:0] amount;
  } cost_req_t;

endpackage

// ===== hdl/fifo_cache_hit_cost_counter.sv =====
// FIFO-replacement key cache with a saturating access-cost total. A request is
// taken when start is high and busy is low; its result appears on out_was_hit
// and out_total_cost for exactly one cycle, marked by out_valid, and cannot be
// held off. The stored keys are searched one entry per cycle through a single
// 64-bit comparator fed by a registered-read key memory. A miss searches every
// held key, a hit ends the search at the matching entry, and a request to an
// empty cache skips the search. A new start can be taken in the cycle its
// result is shown. A capacity write empties the cache but keeps the total.
`include "fifo_cache_hit_cost_counter_macros.svh"

module fifo_cache_hit_cost_counter #(
  parameter int ENTRIES = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [fhc_pkg::KEY_W-1:0]      in_request_key,
  output logic                           out_valid,
  output logic                           out_was_hit,
  output logic [fhc_pkg::TOTAL_W-1:0]    out_total_cost,
  input  logic                           cfg_we,
  input  logic [fhc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fhc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fhc_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_UPDATE = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              pend_r, pend_nxt;
  logic              last_r, last_nxt;
  logic              hit_r, hit_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [IDX_W-1:0]  oldest_r, oldest_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_hit_r, out_hit_nxt;
  logic [CAP_W-1:0]  cap_r, cap_nxt;
  logic [COST_W-1:0] hit_cost_r, hit_cost_nxt;
  logic [COST_W-1:0] miss_cost_r, miss_cost_nxt;

  logic [CNT_W-1:0]  eff_cap;
  logic [CNT_W-1:0]  fill_m1;
  logic [CNT_W-1:0]  oldest_inc;
  logic              st_we;
  logic [IDX_W-1:0]  st_widx;
  logic [KEY_W-1:0]  rd_key;
  logic              key_match;
  logic              cache_full;
  cost_req_t         cost_req;
  logic [TOTAL_W-1:0] total;

  fhc_key_store #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_store (
    .clk    (clk),
    .wr_en  (st_we),
    .wr_idx (st_widx),
    .wr_key (key_r),
    .rd_idx (idx_r),
    .rd_key (rd_key)
  );

  fhc_cost_acc u_cost (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cost_req),
    .total (total)
  );

  always_comb begin
    eff_cap = (CMP_W'(cap_r) > CMP_W'(ENTRIES)) ? CNT_W'(ENTRIES) : CNT_W'(cap_r);
  end

  assign fill_m1    = fill_r - CNT_W'(1);
  assign oldest_inc = CNT_W'(oldest_r) + CNT_W'(1);
  assign key_match  = (rd_key == key_r);
  assign cache_full = (fill_r == eff_cap) && (eff_cap != '0);

  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    idx_nxt       = idx_r;
    pend_nxt      = 1'b0;
    last_nxt      = (CNT_W'(idx_r) == fill_m1);
    hit_nxt       = hit_r;
    fill_nxt      = fill_r;
    oldest_nxt    = oldest_r;
    out_valid_nxt = 1'b0;
    out_hit_nxt   = out_hit_r;
    cap_nxt       = cap_r;
    hit_cost_nxt  = hit_cost_r;
    miss_cost_nxt = miss_cost_r;
    st_we         = 1'b0;
    st_widx       = fill_r[IDX_W-1:0];
    cost_req      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          key_nxt   = in_request_key;
          idx_nxt   = '0;
          hit_nxt   = 1'b0;
          state_nxt = (fill_r == '0) ? S_UPDATE : S_SEARCH;
        end
      end
      S_SEARCH: begin
        // The read issued last cycle is compared now; pend_r and last_r
        // travel alongside that read.
        pend_nxt = 1'b1;
        if (CNT_W'(idx_r) != fill_m1) begin
          idx_nxt = idx_r + IDX_W'(1);
        end
        if (pend_r && key_match) begin
          hit_nxt   = 1'b1;
          pend_nxt  = 1'b0;
          state_nxt = S_UPDATE;
        end else if (pend_r && last_r) begin
          pend_nxt  = 1'b0;
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        out_valid_nxt   = 1'b1;
        out_hit_nxt     = hit_r;
        cost_req.add    = 1'b1;
        cost_req.amount = hit_r ? hit_cost_r : miss_cost_r;
        if (!hit_r && eff_cap != '0) begin
          st_we = 1'b1;
          if (fill_r < eff_cap) begin
            st_widx  = fill_r[IDX_W-1:0];
            fill_nxt = fill_r + CNT_W'(1);
          end else begin
            st_widx    = oldest_r;
            oldest_nxt = (oldest_inc >= eff_cap) ? '0 : oldest_r + IDX_W'(1);
          end
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we) begin
      unique case (cfg_index)
        REG_CAPACITY: begin
          cap_nxt    = cfg_data[CAP_W-1:0];
          fill_nxt   = '0;
          oldest_nxt = '0;
        end
        REG_HIT_COST:  hit_cost_nxt  = cfg_data[COST_W-1:0];
        REG_MISS_COST: miss_cost_nxt = cfg_data[COST_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      fill_r      <= '0;
      oldest_r    <= '0;
      out_valid_r <= 1'b0;
      cap_r       <= CAPACITY_RST;
      hit_cost_r  <= HIT_COST_RST;
      miss_cost_r <= MISS_COST_RST;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      fill_r      <= fill_nxt;
      oldest_r    <= oldest_nxt;
      out_valid_r <= out_valid_nxt;
      cap_r       <= cap_nxt;
      hit_cost_r  <= hit_cost_nxt;
      miss_cost_r <= miss_cost_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    idx_r     <= idx_nxt;
    last_r    <= last_nxt;
    hit_r     <= hit_nxt;
    out_hit_r <= out_hit_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_was_hit    = out_hit_r;
  assign out_total_cost = total;

  `FHC_ASSERT_NEXT(a_strobe_single, out_valid_r, !out_valid_r, "result strobe too long")
  `FHC_ASSERT_HOLD(a_fill_bound, fill_r <= eff_cap, "fill count above capacity")
  `FHC_ASSERT_IMPL(a_empty_miss, (state_r == S_UPDATE) && (fill_r == '0), !hit_r, "empty hit")
  `FHC_ASSERT_IMPL(a_oldest_bound, cache_full, CNT_W'(oldest_r) < eff_cap, "oldest too high")

endmodule

// ===== hdl/fhc_key_store.sv =====
module fhc_key_store #(
  parameter int ENTRIES = 32,
  parameter int IDX_W   = 5
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [IDX_W-1:0]         wr_idx,
  input  logic [fhc_pkg::KEY_W-1:0] wr_key,
  input  logic [IDX_W-1:0]         rd_idx,
  output logic [fhc_pkg::KEY_W-1:0] rd_key
);
  import fhc_pkg::*;

  logic [KEY_W-1:0] mem [ENTRIES];
  logic [KEY_W-1:0] rd_key_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_key;
    end
  end

  always_ff @(posedge clk) begin
    rd_key_r <= mem[rd_idx];
  end

  assign rd_key = rd_key_r;

endmodule

// ===== hdl/fhc_cost_acc.sv =====
`include "fifo_cache_hit_cost_counter_macros.svh"

module fhc_cost_acc (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fhc_pkg::cost_req_t          req,
  output logic [fhc_pkg::TOTAL_W-1:0] total
);
  import fhc_pkg::*;

  logic [TOTAL_W-1:0] total_r;
  logic [TOTAL_W-1:0] total_nxt;
  logic [TOTAL_W:0]   sum;

  always_comb begin
    sum       = {1'b0, total_r} + (TOTAL_W + 1)'(req.amount);
    total_nxt = total_r;
    if (req.add) begin
      // The carry out means the total has passed its maximum; clamp there.
      total_nxt = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else begin
      total_r <= total_nxt;
    end
  end

  assign total = total_r;

  `FHC_ASSERT_NEXT(a_total_monotonic, req.add, total_r >= $past(total_r), "total decreased")

endmodule
